@@ hw/rtl/roms_pkg.sv @@
// ----------------------------------------------------------------------------
// roms_pkg: shared types and constants
// Field widths, operation codes and the controller state type of the read
// overlap mismatch scorer.
// ----------------------------------------------------------------------------
package roms_pkg;

   // Fixed field widths.
   localparam int OP_W        = 2;
   localparam int POS_W       = 9;
   localparam int BASE_W      = 4;
   localparam int LEN_W       = 10;
   localparam int SCORE_W     = 31;
   localparam int COUNT_W     = 10;
   // Width of mismatches squared plus one (1023 * 1023 + 1 fits in 20 bits).
   localparam int SQ_W        = 20;

   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [BASE_W-1:0]  BASE_UNKNOWN = 4'hF;
   localparam logic [SCORE_W-1:0] SCORE_MAX    = 31'h7FFF_FFFF;

   // Operation codes carried on req_tuser.
   localparam logic [OP_W-1:0] OP_LOAD_FWD = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_REV = 2'd1;
   localparam logic [OP_W-1:0] OP_SCORE    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   // Status returned by the serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ hw/rtl/roms_base_store.sv @@
// ----------------------------------------------------------------------------
// roms_base_store: base mask memory
// One synchronous memory of nucleotide masks, one write port and one read
// port with registered read data.
// ----------------------------------------------------------------------------
module roms_base_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic [roms_pkg::BASE_W-1:0] wr_data,
   input  logic [AW-1:0]              rd_addr,
   output logic [roms_pkg::BASE_W-1:0] rd_data
);
   import roms_pkg::*;

   logic [BASE_W-1:0] mem_ff [DEPTH];
   logic [BASE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/roms_divider.sv @@
// ----------------------------------------------------------------------------
// roms_divider: serial restoring divider
// Divides a DW-bit dividend by a count, one quotient bit per cycle. The
// quotient stays valid after done until the next start.
// ----------------------------------------------------------------------------
module roms_divider #(
   parameter int DW = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [DW-1:0]                dividend,
   input  logic [roms_pkg::COUNT_W-1:0] divisor,
   output logic [DW-1:0]                quotient,
   output roms_pkg::div_stat_type       stat
);
   import roms_pkg::*;

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0]      quo_ff, quo_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [COUNT_W:0]   trial;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      fits    = (trial >= {1'b0, div_ff});
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = CW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DW-2:0], fits};
         rem_in = fits ? COUNT_W'(trial - {1'b0, div_ff}) : COUNT_W'(trial);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ hw/rtl/read_overlap_mismatch_score.sv @@
// ----------------------------------------------------------------------------
// read_overlap_mismatch_score: overlap mismatch scorer for read pairs
// Holds a forward and a reverse read as nucleotide masks and scores a
// candidate overlap between them.
// ----------------------------------------------------------------------------
// Usage. Every request transaction carries an operation on req_tuser. A load
// writes one base mask into the forward or reverse store at the given
// position and gives no response; positions at or beyond MAX_READ are
// dropped. A score request walks the overlap one aligned position per
// cycle, reading both stores, then divides (m*m+1) << FRAC_BITS by the
// compared count in a serial divider, one quotient bit per cycle. When no
// position is compared the divide is skipped. req_tready is high only
// while the controller is idle, so one score runs at a time and no load
// is taken until its response has entered the output register. If the
// receiver stalls, a finished score waits in the controller until the
// output register frees, and the request channel stays stalled meanwhile.
// Reset clears the controller and the output valid; the base stores are not
// cleared, and reading an unwritten base is not allowed.
// ----------------------------------------------------------------------------
module read_overlap_mismatch_score #(
   parameter int MAX_READ  = 512,
   parameter int FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: position[8:0], base[12:9], fwd_len[22:13],
   //        rev_len[32:23], overlap[42:33], zero fill above.
   input  logic [roms_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: op[1:0].
   input  logic [roms_pkg::OP_W-1:0]        req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: score[30:0], mismatch_count[40:31], compared_count[50:41],
   //        zero fill above.
   output logic [roms_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: empty_res[0].
   output logic [0:0]                       rsp_tuser
);
   import roms_pkg::*;

   localparam int AW  = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
   localparam int LW  = $clog2(MAX_READ + 1);
   // Signed walk index width: covers -1023 up to MAX_READ.
   localparam int SW  = ((LW > LEN_W) ? LW : LEN_W) + 1;
   localparam int DW  = SQ_W + FRAC_BITS;

   // Request field unpacking.
   logic [POS_W-1:0]  req_position;
   logic [BASE_W-1:0] req_base;
   logic [LEN_W-1:0]  req_fwd_len;
   logic [LEN_W-1:0]  req_rev_len;
   logic [LEN_W-1:0]  req_overlap;

   assign req_position = req_tdata[8:0];
   assign req_base     = req_tdata[12:9];
   assign req_fwd_len  = req_tdata[22:13];
   assign req_rev_len  = req_tdata[32:23];
   assign req_overlap  = req_tdata[42:33];

   state_type          state_ff, state_in;
   logic [SW-1:0]      fi_ff, fi_in;
   logic [SW-1:0]      ri_ff, ri_in;
   logic [LEN_W-1:0]   cnt_ff, cnt_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [COUNT_W-1:0] mism_ff, mism_in;
   logic [COUNT_W-1:0] comp_ff, comp_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic [COUNT_W-1:0] rsp_mism_ff, rsp_mism_in;
   logic [COUNT_W-1:0] rsp_comp_ff, rsp_comp_in;
   logic               rsp_empty_ff, rsp_empty_in;

   logic               req_accept;
   logic               pos_in_range;
   logic               wr_fwd;
   logic               wr_rev;
   logic [LW-1:0]      flen_clamped;
   logic [LW-1:0]      rlen_clamped;
   logic [BASE_W-1:0]  fwd_base;
   logic [BASE_W-1:0]  rev_base;
   logic               mismatch;
   logic               walk_hit;

   logic               div_start;
   logic [DW-1:0]      div_dividend;
   logic [DW-1:0]      div_quotient;
   div_stat_type       div_stat;
   logic [SQ_W-1:0]    mism_sq;
   logic [63:0]        quo_wide;
   logic [SCORE_W-1:0] score_sat;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign pos_in_range = (32'(req_position) < MAX_READ);

   always_comb begin
      wr_fwd = 1'b0;
      wr_rev = 1'b0;
      unique case (req_tuser)
         OP_LOAD_FWD: wr_fwd = req_accept && pos_in_range;
         OP_LOAD_REV: wr_rev = req_accept && pos_in_range;
         default: begin
         end
      endcase
   end

   // Lengths above MAX_READ are clamped.
   assign flen_clamped = (32'(req_fwd_len) > MAX_READ) ?
                         LW'(MAX_READ) : LW'(req_fwd_len);
   assign rlen_clamped = (32'(req_rev_len) > MAX_READ) ?
                         LW'(MAX_READ) : LW'(req_rev_len);

   roms_base_store #(
      .DEPTH (MAX_READ),
      .AW    (AW)
   ) u_fwd_store (
      .clock   (clock),
      .wr_en   (wr_fwd),
      .wr_addr (AW'(req_position)),
      .wr_data (req_base),
      .rd_addr (fi_ff[AW-1:0]),
      .rd_data (fwd_base)
   );

   roms_base_store #(
      .DEPTH (MAX_READ),
      .AW    (AW)
   ) u_rev_store (
      .clock   (clock),
      .wr_en   (wr_rev),
      .wr_addr (AW'(req_position)),
      .wr_data (req_base),
      .rd_addr (ri_ff[AW-1:0]),
      .rd_data (rev_base)
   );

   // A position lies inside both reads when both indexes are non-negative;
   // the upper bounds hold by construction of the walk.
   assign walk_hit = !fi_ff[SW-1] && !ri_ff[SW-1];
   assign mismatch = (fwd_base == BASE_UNKNOWN) || (rev_base == BASE_UNKNOWN) ||
                     ((fwd_base & rev_base) == '0);

   // Mismatches squared plus one, registered inside the divider at start.
   assign mism_sq      = SQ_W'(mism_ff) * SQ_W'(mism_ff) + SQ_W'(1);
   assign div_dividend = DW'(mism_sq) << FRAC_BITS;
   assign div_start    = (state_ff == ST_MUL) && (comp_ff != '0);

   roms_divider #(
      .DW (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (comp_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   assign quo_wide  = 64'(div_quotient);
   assign score_sat = (quo_wide > 64'(SCORE_MAX)) ? SCORE_MAX : quo_wide[SCORE_W-1:0];

   always_comb begin
      state_in      = state_ff;
      fi_in         = fi_ff;
      ri_in         = ri_ff;
      cnt_in        = cnt_ff;
      cmp_vld_in    = 1'b0;
      mism_in       = mism_ff;
      comp_in       = comp_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_score_in  = rsp_score_ff;
      rsp_mism_in   = rsp_mism_ff;
      rsp_comp_in   = rsp_comp_ff;
      rsp_empty_in  = rsp_empty_ff;

      // Accumulate the compare whose bases arrive this cycle.
      if (cmp_vld_ff) begin
         comp_in = comp_ff + 1'b1;
         if (mismatch) begin
            mism_in = mism_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == OP_SCORE)) begin
               fi_in   = SW'(flen_clamped) - SW'(req_overlap);
               ri_in   = SW'(rlen_clamped) - SW'(1);
               cnt_in  = req_overlap;
               mism_in = '0;
               comp_in = '0;
               state_in = (req_overlap == '0) ? ST_DRAIN : ST_WALK;
            end
         end
         ST_WALK: begin
            cmp_vld_in = walk_hit;
            fi_in      = fi_ff + SW'(1);
            ri_in      = ri_ff - SW'(1);
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == LEN_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = (comp_ff == '0) ? ST_OUT : ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_mism_in   = mism_ff;
               rsp_comp_in   = comp_ff;
               rsp_empty_in  = (comp_ff == '0);
               rsp_score_in  = (comp_ff == '0) ? SCORE_MAX : score_sat;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      fi_ff        <= fi_in;
      ri_ff        <= ri_in;
      cnt_ff       <= cnt_in;
      mism_ff      <= mism_in;
      comp_ff      <= comp_in;
      rsp_score_ff <= rsp_score_in;
      rsp_mism_ff  <= rsp_mism_in;
      rsp_comp_ff  <= rsp_comp_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, rsp_comp_ff, rsp_mism_ff, rsp_score_ff};
   assign rsp_tuser  = rsp_empty_ff;

   // A compare result only follows a walk cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(state_ff == ST_WALK))
      else $error("compare issued outside the overlap walk");

   // New requests are never taken while the divider is working.
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !div_stat.busy)
      else $error("request accepted while divide in progress");

   // Mismatches never exceed compared positions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_mism_ff <= rsp_comp_ff))
      else $error("mismatch count above compared count");

   // An empty result carries a zero compared count and a saturated score.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_empty_ff) |-> (rsp_comp_ff == '0 && rsp_score_ff == SCORE_MAX))
      else $error("empty result with inconsistent fields");

endmodule
